/* rtl/rhi_pkg.sv */
`default_nettype none
package rhi_pkg;
   localparam int MaxWidth   = 256;
   localparam int MaxHeight  = 256;
   localparam int RayCount   = 32;
   localparam int SampleBits = 16;
   localparam int ColBits    = 8;
   localparam int RowBits    = 8;
   localparam int AddrBits   = ColBits + RowBits;
   localparam int DimBits    = 9;
   localparam int RayBits    = 5;
   localparam int AccBits    = 48;
   localparam int WsumBits   = 24;

   localparam logic [0:0] OP_WRITE = 1'b0;
   localparam logic [0:0] OP_QUERY = 1'b1;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [ColBits-1:0]   col;
      logic [RowBits-1:0]   row;
      logic [DimBits-1:0]   w;
      logic [DimBits-1:0]   h;
   } walk_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [SampleBits-1:0] value;
   } walk_rsp_type;

   // cos(2*pi*k/64) in Q1.14
   function automatic logic signed [15:0] cos64(input logic [5:0] k);
      logic [4:0] r;
      logic signed [15:0] q;
      logic [4:0] idx;
      logic [15:0] t;
      r = {1'b0, k[3:0]};
      idx = (k[4]) ? (5'd16 - r) : r;
      unique case (idx)
         5'd0: t = 16'd16384;  5'd1: t = 16'd16305;  5'd2: t = 16'd16069;
         5'd3: t = 16'd15679;  5'd4: t = 16'd15137;  5'd5: t = 16'd14449;
         5'd6: t = 16'd13623;  5'd7: t = 16'd12665;  5'd8: t = 16'd11585;
         5'd9: t = 16'd10394;  5'd10: t = 16'd9102;  5'd11: t = 16'd7723;
         5'd12: t = 16'd6270;  5'd13: t = 16'd4756;  5'd14: t = 16'd3196;
         5'd15: t = 16'd1606;  default: t = 16'd0;
      endcase
      q = signed'(t);
      // quadrants 1 and 2 negative
      if (k[5] ^ k[4]) cos64 = -q;
      else cos64 = q;
   endfunction
endpackage
`default_nettype wire

/* rtl/rhi_divider.sv */
`default_nettype none
module rhi_divider
   import rhi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [AccBits-1:0]  dividend,
   input  wire logic [WsumBits-1:0] divisor,
   output logic                     done,
   output logic [SampleBits-1:0]    quotient
);
   logic [AccBits-1:0]  num_ff, num_in;
   logic [WsumBits:0]   rem_ff, rem_in;
   logic [WsumBits-1:0] den_ff, den_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [WsumBits:0]   sh;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      sh = {rem_ff[WsumBits-1:0], num_ff[AccBits-1]};
      if (start) begin
         num_in = dividend; rem_in = '0; den_in = divisor;
         cnt_in = 6'(AccBits); run_in = 1'b1;
      end else if (run_ff) begin
         // one quotient bit a cycle, restoring
         if (sh >= {1'b0, den_ff}) begin
            rem_in = sh - {1'b0, den_ff};
            num_in = {num_ff[AccBits-2:0], 1'b1};
         end else begin
            rem_in = sh;
            num_in = {num_ff[AccBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = num_ff[SampleBits-1:0];
endmodule
`default_nettype wire

/* rtl/rhi_ray_walker.sv */
`default_nettype none
module rhi_ray_walker
   import rhi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire walk_cmd_type          cmd,
   output logic [AddrBits-1:0]        rd_addr,
   input  wire logic [SampleBits-1:0] rd_data,
   output walk_rsp_type               rsp
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CTR   = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_WAIT  = 3'd6;

   logic [2:0]            st_ff, st_in;
   logic [ColBits-1:0]    x_ff, x_in;
   logic [RowBits-1:0]    y_ff, y_in;
   logic [DimBits-1:0]    w_ff, w_in, h_ff, h_in, dist_ff, dist_in;
   logic [RayBits-1:0]    ray_ff, ray_in;
   logic [DimBits-1:0]    j_ff, j_in;
   logic [AccBits-1:0]    acc_ff, acc_in;
   logic [WsumBits-1:0]   wsum_ff, wsum_in;
   logic [16:0]           wt_ff, wt_in;
   logic [AddrBits-1:0]   addr_ff, addr_in;
   logic                  dstart;
   logic                  ddone;
   logic [SampleBits-1:0] quo;
   logic [AccBits-1:0]    dividend;

   logic [5:0]         k;
   logic signed [15:0] dx, dy;
   logic signed [27:0] px, py;
   logic [16:0]        wdiv;
   logic [17:0]        jtenth;
   logic [DimBits-1:0] jnext;
   logic [DimBits-1:0] cx_full, cy_full;
   logic [ColBits-1:0] cx;
   logic [RowBits-1:0] cy;
   logic [23:0]        wt100;

   function automatic logic [DimBits-1:0] clampc(input logic signed [27:0] p,
                                                 input logic [DimBits-1:0] lim);
      logic [13:0] c;
      c = p[27:14];
      if (p < 0) clampc = '0;
      else if ({1'b0, c} >= {6'd0, lim}) clampc = lim - 9'd1;
      else clampc = c[DimBits-1:0];
   endfunction

   // floor(65536/j) for every distance the ray walk can reach
   function automatic logic [16:0] recip_q16(input logic [DimBits-1:0] j);
      unique case (j)
         9'd1: recip_q16 = 17'd65536;   9'd2: recip_q16 = 17'd32768;
         9'd3: recip_q16 = 17'd21845;   9'd4: recip_q16 = 17'd16384;
         9'd5: recip_q16 = 17'd13107;   9'd6: recip_q16 = 17'd10922;
         9'd7: recip_q16 = 17'd9362;    9'd8: recip_q16 = 17'd8192;
         9'd9: recip_q16 = 17'd7281;    9'd10: recip_q16 = 17'd6553;
         9'd11: recip_q16 = 17'd5957;   9'd12: recip_q16 = 17'd5461;
         9'd13: recip_q16 = 17'd5041;   9'd14: recip_q16 = 17'd4681;
         9'd15: recip_q16 = 17'd4369;   9'd16: recip_q16 = 17'd4096;
         9'd17: recip_q16 = 17'd3855;   9'd18: recip_q16 = 17'd3640;
         9'd19: recip_q16 = 17'd3449;   9'd20: recip_q16 = 17'd3276;
         9'd22: recip_q16 = 17'd2978;   9'd24: recip_q16 = 17'd2730;
         9'd26: recip_q16 = 17'd2520;   9'd28: recip_q16 = 17'd2340;
         9'd30: recip_q16 = 17'd2184;   9'd33: recip_q16 = 17'd1985;
         9'd36: recip_q16 = 17'd1820;   9'd39: recip_q16 = 17'd1680;
         9'd42: recip_q16 = 17'd1560;   9'd46: recip_q16 = 17'd1424;
         9'd50: recip_q16 = 17'd1310;   9'd55: recip_q16 = 17'd1191;
         9'd60: recip_q16 = 17'd1092;   9'd66: recip_q16 = 17'd992;
         9'd72: recip_q16 = 17'd910;    9'd79: recip_q16 = 17'd829;
         9'd86: recip_q16 = 17'd762;    9'd94: recip_q16 = 17'd697;
         9'd103: recip_q16 = 17'd636;   9'd113: recip_q16 = 17'd579;
         9'd124: recip_q16 = 17'd528;   9'd136: recip_q16 = 17'd481;
         9'd149: recip_q16 = 17'd439;   9'd163: recip_q16 = 17'd402;
         9'd179: recip_q16 = 17'd366;   9'd196: recip_q16 = 17'd334;
         9'd215: recip_q16 = 17'd304;   9'd236: recip_q16 = 17'd277;
         default: recip_q16 = '0;
      endcase
   endfunction

   always_comb begin
      k  = {ray_ff, 1'b0};
      dx = cos64(k);
      dy = cos64(k + 6'd48);
      px = (28'(x_ff) <<< 14) + 28'(dx) * signed'({19'd0, j_ff}) + 28'sd8192;
      py = (28'(y_ff) <<< 14) + 28'(dy) * signed'({19'd0, j_ff}) + 28'sd8192;
      cx_full = clampc(px, w_ff);
      cy_full = clampc(py, h_ff);
      cx = cx_full[ColBits-1:0];
      cy = cy_full[RowBits-1:0];
      wdiv = recip_q16(j_ff);
      // j/10 as (j*205) >> 11, exact below 1029
      jtenth = 18'(j_ff) * 18'd205;
      jnext = (j_ff < 9'd16) ? j_ff + 9'd1 : j_ff + 9'(jtenth >> 11);
      wt100 = 24'(wt_ff) * 24'd100;
   end

   always_comb begin
      st_in = st_ff; x_in = x_ff; y_in = y_ff; w_in = w_ff; h_in = h_ff;
      dist_in = dist_ff; ray_in = ray_ff; j_in = j_ff; acc_in = acc_ff;
      wsum_in = wsum_ff; wt_in = wt_ff; addr_in = addr_ff; dstart = 1'b0;
      rsp.done = 1'b0; rsp.value = quo;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               x_in = cmd.col; y_in = cmd.row;
               w_in = (cmd.w == 9'd0) ? 9'd1 : cmd.w;
               h_in = (cmd.h == 9'd0) ? 9'd1 : cmd.h;
               addr_in = {cmd.row, cmd.col};
               st_in = ST_CTR;
            end
         end
         ST_CTR: st_in = ST_WAIT;
         ST_WAIT: begin
            if (rd_data != '0) begin
               rsp.done = 1'b1; rsp.value = rd_data; st_in = ST_IDLE;
            end else begin
               dist_in = (w_ff > h_ff) ? w_ff : h_ff;
               acc_in = '0; wsum_in = '0; ray_in = '0; j_in = 9'd1;
               st_in = ST_STEP;
            end
         end
         ST_STEP: begin
            wt_in = wdiv;
            addr_in = {cy, cx};
            if (j_ff >= dist_ff) begin
               if (ray_ff == RayBits'(RayCount - 1)) st_in = ST_DIV;
               else begin
                  ray_in = ray_ff + RayBits'(1); j_in = 9'd1;
               end
            end else if (j_ff < 9'd64 && ray_ff[0]) j_in = jnext;
            else st_in = ST_READ;
         end
         ST_READ: begin
            if (wt100 < wsum_ff) begin
               j_in = jnext; st_in = ST_STEP;
            end else st_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_data == '0) j_in = jnext;
            else begin
               acc_in = acc_ff + AccBits'(rd_data) * AccBits'(wt_ff);
               wsum_in = wsum_ff + WsumBits'(wt_ff);
               j_in = dist_ff;
            end
            st_in = ST_STEP;
         end
         ST_DIV: begin
            if (wsum_ff == '0) begin
               rsp.done = 1'b1; rsp.value = '0; st_in = ST_IDLE;
            end else if (ddone) begin
               rsp.done = 1'b1; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_STEP && st_in == ST_DIV) dstart = 1'b1;
   end

   assign dividend = acc_ff + AccBits'(wsum_ff >> 1);

   rhi_divider u_div (
      .clock(clock), .reset(reset), .start(dstart && wsum_ff != '0),
      .dividend(dividend), .divisor(wsum_ff), .done(ddone), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; w_ff <= w_in; h_ff <= h_in; dist_ff <= dist_in;
      ray_ff <= ray_in; j_ff <= j_in; acc_ff <= acc_in; wsum_ff <= wsum_in;
      wt_ff <= wt_in; addr_ff <= addr_in;
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   assign rd_addr = addr_ff;
endmodule
`default_nettype wire

/* rtl/radial_hole_inpainter_core.sv */
`default_nettype none
// A query on a stored nonzero sample is answered from ST_WAIT, once the walker has
// passed ST_CTR and the memory read is registered. A hole walks 32 rays through
// the single pixel memory read port, with skipped odd-ray steps, steps dropped on
// weight and probes, then a bit-serial divide when any ray found a sample. A write
// is stored in the pixel memory without raising busy. busy is high throughout a
// query; results cannot be stalled.
module radial_hole_inpainter_core
   import rhi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_operation,
   input  wire logic [ColBits-1:0]    req_col,
   input  wire logic [RowBits-1:0]    req_row,
   input  wire logic [SampleBits-1:0] req_sample,
   output logic                       rsp_strobe,
   output logic [SampleBits-1:0]      rsp_filled_value,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [0:0]            csr_index,
   input  wire logic [DimBits-1:0]    csr_data
);
   logic [SampleBits-1:0] mem [0:MaxWidth*MaxHeight-1];
   logic [SampleBits-1:0] rd_data_ff;
   logic [AddrBits-1:0]   rd_addr;
   logic [DimBits-1:0]    width_ff, height_ff;
   logic                  busy_ff, busy_in;
   logic                  accept;
   walk_cmd_type          cmd;
   walk_rsp_type          wrsp;

   assign accept = start && !busy_ff;
   assign cmd.start = accept && req_operation == OP_QUERY;
   assign cmd.col = req_col;
   assign cmd.row = req_row;
   assign cmd.w = (width_ff > 9'(MaxWidth)) ? 9'(MaxWidth) : width_ff;
   assign cmd.h = (height_ff > 9'(MaxHeight)) ? 9'(MaxHeight) : height_ff;

   always_ff @(posedge clock) begin
      if (accept && req_operation == OP_WRITE) mem[{req_row, req_col}] <= req_sample;
      rd_data_ff <= mem[rd_addr];
   end

   rhi_ray_walker u_walk (
      .clock(clock), .reset(reset), .cmd(cmd), .rd_addr(rd_addr),
      .rd_data(rd_data_ff), .rsp(wrsp)
   );

   always_comb begin
      busy_in = busy_ff;
      if (cmd.start) busy_in = 1'b1;
      else if (wrsp.done) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         width_ff <= 9'd256;
         height_ff <= 9'd256;
      end else begin
         busy_ff <= busy_in;
         if (csr_valid && csr_index == CSR_WIDTH) width_ff <= csr_data;
         if (csr_valid && csr_index == CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   assign busy = busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_strobe = wrsp.done;
   assign rsp_filled_value = wrsp.value;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while idle");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("busy after result");
   a_query: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation) |=> busy) else $error("query not taken");
endmodule
`default_nettype wire

/* bench/radial_hole_inpainter_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module radial_hole_inpainter_core_tb;
   import rhi_pkg::*;

   localparam int CycleLimit = 3000000;

   typedef struct {
      logic                  op;
      logic [ColBits-1:0]    col;
      logic [RowBits-1:0]    row;
      logic [SampleBits-1:0] sample;
   } pixel_cmd_type;

   localparam int QuarterCos [17] = '{16384, 16305, 16069, 15679, 15137, 14449, 13623,
      12665, 11585, 10394, 9102, 7723, 6270, 4756, 3196, 1606, 0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_operation = 1'b0;
   logic [ColBits-1:0]    req_col = '0;
   logic [RowBits-1:0]    req_row = '0;
   logic [SampleBits-1:0] req_sample = '0;
   logic                  rsp_strobe;
   logic [SampleBits-1:0] rsp_filled_value;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [0:0]            csr_index = '0;
   logic [DimBits-1:0]    csr_data = '0;

   radial_hole_inpainter_core uut (
      .clock, .reset, .start, .busy, .req_operation, .req_col, .req_row, .req_sample,
      .rsp_strobe, .rsp_filled_value, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // prediction state
   logic [SampleBits-1:0] plane [MaxWidth*MaxHeight];
   logic [DimBits-1:0]    width_reg = 9'd256;
   logic [DimBits-1:0]    height_reg = 9'd256;

   pixel_cmd_type         pending_cmds[$];
   logic [SampleBits-1:0] expected_fills[$];
   bit                    written [MaxWidth*MaxHeight];
   int                    written_addrs[$];

   int  errors = 0;
   int  cycles = 0;
   int  accepted = 0;
   int  n_writes = 0;
   int  n_queries = 0;
   int  n_holes = 0;
   int  idle_pct = 7;
   int  seen_accepts = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int dir_q14(input int k);
      int q;
      int r;
      q = (k >> 4) & 3;
      r = k & 15;
      case (q)
         0: return QuarterCos[r];
         1: return -QuarterCos[16-r];
         2: return -QuarterCos[r];
         default: return QuarterCos[16-r];
      endcase
   endfunction

   function automatic int probe(input int base, input int dir, input int j, input int lim);
      longint p;
      p = (longint'(base) << 14) + longint'(dir) * j + 8192;
      if (p < 0) return 0;
      p = p >>> 14;
      if (p >= lim) p = lim - 1;
      return int'(p);
   endfunction

   function automatic int eff_dim(input logic [DimBits-1:0] v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic logic [SampleBits-1:0] fill_at(input int x, input int y);
      int w;
      int h;
      int reach;
      int dx;
      int dy;
      int k;
      int j;
      longint unsigned acc;
      longint unsigned wsum;
      longint unsigned wt;
      logic [SampleBits-1:0] v;
      w = eff_dim(width_reg, MaxWidth);
      h = eff_dim(height_reg, MaxHeight);
      reach = (w > h) ? w : h;
      acc = 0;
      wsum = 0;
      if (plane[y*MaxWidth+x] != 0) return plane[y*MaxWidth+x];
      for (int i = 0; i < RayCount; i++) begin
         k = ((i * 64) / RayCount) & 63;
         dx = dir_q14(k);
         dy = dir_q14((k + 48) & 63);
         for (j = 1; j < reach; j = (j < 16) ? j + 1 : j + j / 10) begin
            if (j < 64 && (i & 1)) continue;
            wt = 65536 / j;
            if (wt * 100 < wsum) continue;
            v = plane[probe(y, dy, j, h)*MaxWidth + probe(x, dx, j, w)];
            if (v == 0) continue;
            acc += longint'(v) * wt;
            wsum += wt;
            break;
         end
      end
      if (wsum == 0) return '0;
      return SampleBits'((acc + wsum / 2) / wsum);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && seen_accepts == accepted)) begin
         seen_accepts = accepted;
         if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_operation <= pending_cmds[0].op;
            req_col <= pending_cmds[0].col;
            req_row <= pending_cmds[0].row;
            req_sample <= pending_cmds[0].sample;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: transfer in, result out
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_fills.size() == 0) begin
            $error("filled_value: none expected, got %h", rsp_filled_value);
            errors++;
         end else begin
            if (rsp_filled_value !== expected_fills[0]) begin
               $error("filled_value: expected %h, got %h", expected_fills[0],
                      rsp_filled_value);
               errors++;
            end
            void'(expected_fills.pop_front());
         end
      end
      if (!reset && start && !busy) begin
         void'(pending_cmds.pop_front());
         accepted++;
         if (req_operation == OP_WRITE) begin
            plane[req_row*MaxWidth+req_col] = req_sample;
            n_writes++;
         end else begin
            if (plane[req_row*MaxWidth+req_col] == 0) n_holes++;
            expected_fills.push_back(fill_at(req_col, req_row));
            n_queries++;
         end
      end
   end

   task automatic push_cmd(input logic op, input int col, input int row, input int smp);
      pixel_cmd_type c;
      c.op = op;
      c.col = ColBits'(col);
      c.row = RowBits'(row);
      c.sample = SampleBits'(smp);
      pending_cmds.push_back(c);
      if (op == OP_WRITE && !written[row*MaxWidth+col]) begin
         written[row*MaxWidth+col] = 1'b1;
         written_addrs.push_back(row*MaxWidth+col);
      end
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || expected_fills.size() > 0 || busy || start)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= DimBits'(val);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WIDTH) width_reg = DimBits'(val);
      else height_reg = DimBits'(val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_sample(input int zero_pct, output int s);
      s = ($urandom_range(99) < zero_pct) ? 0 : $urandom_range(65535);
   endtask

   // load the whole image in use, then mix queries with rewrites
   task automatic run_phase(input int wr, input int hr, input int zero_pct,
                            input int nq);
      int w;
      int h;
      int s;
      int a;
      drain();
      csr_write(CSR_WIDTH, wr);
      csr_write(CSR_HEIGHT, hr);
      w = eff_dim(DimBits'(wr), MaxWidth);
      h = eff_dim(DimBits'(hr), MaxHeight);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            random_sample(zero_pct, s);
            push_cmd(OP_WRITE, c, r, s);
         end
      for (int n = 0; n < nq; n++) begin
         if ($urandom_range(4) == 0) begin
            random_sample(zero_pct, s);
            push_cmd(OP_WRITE, $urandom_range(w-1), $urandom_range(h-1), s);
         end
         if ($urandom_range(2) == 0) begin
            a = written_addrs[$urandom_range(written_addrs.size()-1)];
            push_cmd(OP_QUERY, a % MaxWidth, a / MaxWidth, $urandom_range(65535));
         end else begin
            push_cmd(OP_QUERY, $urandom_range(w-1), $urandom_range(h-1),
                     $urandom_range(65535));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tiny image, all holes then partly filled, far corners outside the image
      idle_pct = 7;
      csr_write(CSR_WIDTH, 2);
      csr_write(CSR_HEIGHT, 2);
      push_cmd(OP_WRITE, 0, 0, 0);
      push_cmd(OP_WRITE, 1, 0, 0);
      push_cmd(OP_WRITE, 0, 1, 0);
      push_cmd(OP_WRITE, 1, 1, 0);
      push_cmd(OP_WRITE, 255, 255, 16'hFFFF);
      push_cmd(OP_WRITE, 200, 100, 0);
      push_cmd(OP_QUERY, 0, 0, 16'hFFFF);
      push_cmd(OP_QUERY, 255, 255, 0);
      push_cmd(OP_QUERY, 200, 100, 0);
      push_cmd(OP_WRITE, 1, 1, 16'h8000);
      push_cmd(OP_WRITE, 0, 1, 16'h0001);
      push_cmd(OP_QUERY, 0, 0, 0);
      push_cmd(OP_QUERY, 1, 0, 0);
      push_cmd(OP_QUERY, 200, 100, 0);
      push_cmd(OP_QUERY, 1, 1, 0);

      // size extremes; out-of-range register values clamp
      run_phase(0, 511, 60, 12);
      idle_pct = 76;
      run_phase(1, 1, 30, 6);
      run_phase($urandom_range(2, 4), $urandom_range(2, 4), 40, 8);
      run_phase($urandom_range(1, 6), $urandom_range(1, 3), 50, 8);
      idle_pct = 0;
      run_phase($urandom_range(2, 4), $urandom_range(2, 4), 40, 8);
      run_phase($urandom_range(1, 3), $urandom_range(1, 6), 70, 8);
      drain();
      repeat (60) @(posedge clock);

      $display("Ran %0d transfers: %0d writes, %0d queries of which %0d on holes.",
               accepted, n_writes, n_queries, n_holes);
      $display("Image sizes from 1x1 up to 256 high, clamped register values too.");
      if (errors == 0 && expected_fills.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
